@@ rtl/pfa_pkg.sv @@
// ----------------------------------------------------------------------------
// Page frame allocator package
// Shared types, codes and the control store of the allocator's sequencer.
// ----------------------------------------------------------------------------
package pfa_pkg;

   localparam int PAGE_COUNT_W  = 8;
   localparam int CHAIN_HEAD_W  = 7;
   localparam int ALLOC_HEAD_W  = 7;
   localparam int ALLOC_ADDR_W  = 19;
   localparam int FREE_FRAMES_W = 8;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic STATUS_DONE    = 1'b0;
   localparam logic STATUS_REFUSED = 1'b1;

   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_INIT       = 4'd0;
   localparam logic [STEP_W-1:0] STEP_IDLE       = 4'd1;
   localparam logic [STEP_W-1:0] STEP_ADISP      = 4'd2;
   localparam logic [STEP_W-1:0] STEP_ALOOP      = 4'd3;
   localparam logic [STEP_W-1:0] STEP_ACOMMIT    = 4'd4;
   localparam logic [STEP_W-1:0] STEP_RESP_HEAD  = 4'd5;
   localparam logic [STEP_W-1:0] STEP_REFUSE     = 4'd6;
   localparam logic [STEP_W-1:0] STEP_FDISP      = 4'd7;
   localparam logic [STEP_W-1:0] STEP_FLOOP      = 4'd8;
   localparam logic [STEP_W-1:0] STEP_FCOMMIT    = 4'd9;
   localparam logic [STEP_W-1:0] STEP_RESP_PLAIN = 4'd10;

   localparam logic [3:0] COND_NEVER        = 4'd0;
   localparam logic [3:0] COND_START        = 4'd1;
   localparam logic [3:0] COND_START_FREE   = 4'd2;
   localparam logic [3:0] COND_INIT_LAST    = 4'd3;
   localparam logic [3:0] COND_REQ_BAD      = 4'd4;
   localparam logic [3:0] COND_CNT_EQ_COUNT = 4'd5;
   localparam logic [3:0] COND_RDATA_NIL    = 4'd6;
   localparam logic [3:0] COND_FREE_BAD     = 4'd7;
   localparam logic [3:0] COND_WALK_END     = 4'd8;

   localparam logic [1:0] PTR_HOLD      = 2'd0;
   localparam logic [1:0] PTR_FREE_HEAD = 2'd1;
   localparam logic [1:0] PTR_CHEAD     = 2'd2;
   localparam logic [1:0] PTR_RDATA     = 2'd3;

   localparam logic [1:0] CNT_HOLD = 2'd0;
   localparam logic [1:0] CNT_ONE  = 2'd1;
   localparam logic [1:0] CNT_INC  = 2'd2;

   localparam logic [2:0] ADDR_CNT       = 3'd0;
   localparam logic [2:0] ADDR_FREE_HEAD = 3'd1;
   localparam logic [2:0] ADDR_CHEAD     = 3'd2;
   localparam logic [2:0] ADDR_RDATA     = 3'd3;
   localparam logic [2:0] ADDR_PTR       = 3'd4;

   localparam logic [1:0] WD_CNT_NEXT  = 2'd0;
   localparam logic [1:0] WD_NIL       = 2'd1;
   localparam logic [1:0] WD_LINK_HEAD = 2'd2;

   localparam logic [1:0] FH_HOLD     = 2'd0;
   localparam logic [1:0] FH_FROM_CUR = 2'd1;
   localparam logic [1:0] FH_CHEAD    = 2'd2;

   localparam logic [1:0] TOT_HOLD = 2'd0;
   localparam logic [1:0] TOT_SUB  = 2'd1;
   localparam logic [1:0] TOT_ADD  = 2'd2;

   localparam logic [1:0] RSP_NONE   = 2'd0;
   localparam logic [1:0] RSP_HEAD   = 2'd1;
   localparam logic [1:0] RSP_PLAIN  = 2'd2;
   localparam logic [1:0] RSP_REFUSE = 2'd3;

   typedef struct packed {
      logic              idle;
      logic [3:0]        cond_a;
      logic [STEP_W-1:0] tgt_a;
      logic [3:0]        cond_b;
      logic [STEP_W-1:0] tgt_b;
      logic [STEP_W-1:0] tgt_else;
      logic [1:0]        ptr_sel;
      logic [1:0]        cnt_op;
      logic              head_ld;
      logic              cur_ld;
      logic [2:0]        addr_sel;
      logic              mem_we;
      logic [1:0]        wd_sel;
      logic [1:0]        fh_op;
      logic [1:0]        tot_op;
      logic [1:0]        rsp_op;
   } ucode_word_type;

   typedef struct packed {
      logic start;
      logic start_free;
      logic init_last;
      logic req_bad;
      logic cnt_eq_count;
      logic rdata_nil;
      logic free_bad;
      logic walk_end;
   } seq_flags_type;

   function automatic logic cond_true(input logic [3:0] cond, input seq_flags_type f);
      logic hit;
      hit = 1'b0;
      case (cond)
         COND_NEVER:        hit = 1'b0;
         COND_START:        hit = f.start;
         COND_START_FREE:   hit = f.start_free;
         COND_INIT_LAST:    hit = f.init_last;
         COND_REQ_BAD:      hit = f.req_bad;
         COND_CNT_EQ_COUNT: hit = f.cnt_eq_count;
         COND_RDATA_NIL:    hit = f.rdata_nil;
         COND_FREE_BAD:     hit = f.free_bad;
         COND_WALK_END:     hit = f.walk_end;
         default:           hit = 1'b0;
      endcase
      return hit;
   endfunction

   function automatic ucode_word_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_word_type w;
      w = '0;
      case (step)
         STEP_INIT: begin
            w.mem_we   = 1'b1;
            w.addr_sel = ADDR_CNT;
            w.wd_sel   = WD_CNT_NEXT;
            w.cnt_op   = CNT_INC;
            w.cond_a   = COND_INIT_LAST;
            w.tgt_a    = STEP_IDLE;
            w.tgt_else = STEP_INIT;
         end
         STEP_IDLE: begin
            w.idle     = 1'b1;
            w.cond_a   = COND_START_FREE;
            w.tgt_a    = STEP_FDISP;
            w.cond_b   = COND_START;
            w.tgt_b    = STEP_ADISP;
            w.tgt_else = STEP_IDLE;
         end
         STEP_ADISP: begin
            w.cond_a   = COND_REQ_BAD;
            w.tgt_a    = STEP_REFUSE;
            w.ptr_sel  = PTR_FREE_HEAD;
            w.head_ld  = 1'b1;
            w.cnt_op   = CNT_ONE;
            w.addr_sel = ADDR_FREE_HEAD;
            w.tgt_else = STEP_ALOOP;
         end
         STEP_ALOOP: begin
            w.cur_ld   = 1'b1;
            w.cond_a   = COND_CNT_EQ_COUNT;
            w.tgt_a    = STEP_ACOMMIT;
            w.cond_b   = COND_RDATA_NIL;
            w.tgt_b    = STEP_REFUSE;
            w.ptr_sel  = PTR_RDATA;
            w.cnt_op   = CNT_INC;
            w.addr_sel = ADDR_RDATA;
            w.tgt_else = STEP_ALOOP;
         end
         STEP_ACOMMIT: begin
            w.mem_we   = 1'b1;
            w.addr_sel = ADDR_PTR;
            w.wd_sel   = WD_NIL;
            w.fh_op    = FH_FROM_CUR;
            w.tot_op   = TOT_SUB;
            w.tgt_else = STEP_RESP_HEAD;
         end
         STEP_RESP_HEAD: begin
            w.rsp_op   = RSP_HEAD;
            w.tgt_else = STEP_IDLE;
         end
         STEP_REFUSE: begin
            w.rsp_op   = RSP_REFUSE;
            w.tgt_else = STEP_IDLE;
         end
         STEP_FDISP: begin
            w.cond_a   = COND_FREE_BAD;
            w.tgt_a    = STEP_RESP_PLAIN;
            w.ptr_sel  = PTR_CHEAD;
            w.cnt_op   = CNT_ONE;
            w.addr_sel = ADDR_CHEAD;
            w.tgt_else = STEP_FLOOP;
         end
         STEP_FLOOP: begin
            w.cond_a   = COND_WALK_END;
            w.tgt_a    = STEP_FCOMMIT;
            w.ptr_sel  = PTR_RDATA;
            w.cnt_op   = CNT_INC;
            w.addr_sel = ADDR_RDATA;
            w.tgt_else = STEP_FLOOP;
         end
         STEP_FCOMMIT: begin
            w.mem_we   = 1'b1;
            w.addr_sel = ADDR_PTR;
            w.wd_sel   = WD_LINK_HEAD;
            w.fh_op    = FH_CHEAD;
            w.tot_op   = TOT_ADD;
            w.tgt_else = STEP_RESP_PLAIN;
         end
         STEP_RESP_PLAIN: begin
            w.rsp_op   = RSP_PLAIN;
            w.tgt_else = STEP_IDLE;
         end
         default: begin
            w.tgt_else = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

@@ rtl/pfa_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read/write port, registered read data, read returns the old contents.
// ----------------------------------------------------------------------------
module pfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/pfa_sequencer.sv @@
// ----------------------------------------------------------------------------
// Allocator sequencer
// Step counter over the control store, with two conditional jumps per step.
// ----------------------------------------------------------------------------
module pfa_sequencer (
   input  logic                    clock,
   input  logic                    reset,
   input  pfa_pkg::seq_flags_type  flags,
   output pfa_pkg::ucode_word_type ctrl,
   output logic                    adv
);

   import pfa_pkg::*;

   logic [STEP_W-1:0] upc_ff;
   logic [STEP_W-1:0] upc_in;
   logic              hit_a;
   logic              hit_b;

   assign ctrl  = ucode_rom(upc_ff);
   assign hit_a = cond_true(ctrl.cond_a, flags);
   assign hit_b = cond_true(ctrl.cond_b, flags);
   assign adv   = !hit_a && !hit_b;

   always_comb begin
      if (hit_a) begin
         upc_in = ctrl.tgt_a;
      end else if (hit_b) begin
         upc_in = ctrl.tgt_b;
      end else begin
         upc_in = ctrl.tgt_else;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= STEP_INIT;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

@@ rtl/pfa_datapath.sv @@
// ----------------------------------------------------------------------------
// Allocator datapath
// Item registers, list pointers, walk counter, free count and result registers.
// ----------------------------------------------------------------------------
module pfa_datapath #(
   parameter int FRAMES     = 128,
   parameter int PAGE_BYTES = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pfa_pkg::ucode_word_type              ctrl,
   input  logic                                 adv,
   input  logic                                 start,
   input  logic                                 req_cmd,
   input  logic [pfa_pkg::PAGE_COUNT_W-1:0]     req_page_count,
   input  logic [pfa_pkg::CHAIN_HEAD_W-1:0]     req_chain_head,
   input  logic                                 req_chain_present,
   output pfa_pkg::seq_flags_type               flags,
   output logic                                 mem_we,
   output logic [$clog2(FRAMES)-1:0]            mem_addr,
   output logic [$clog2(FRAMES+1)-1:0]          mem_wdata,
   input  logic [$clog2(FRAMES+1)-1:0]          mem_rdata,
   output logic                                 rsp_strobe,
   output logic                                 rsp_status,
   output logic [pfa_pkg::ALLOC_HEAD_W-1:0]     rsp_alloc_head,
   output logic [pfa_pkg::ALLOC_ADDR_W-1:0]     rsp_alloc_addr,
   output logic [pfa_pkg::FREE_FRAMES_W-1:0]    rsp_free_frames
);

   import pfa_pkg::*;

   localparam int LW  = $clog2(FRAMES + 1);
   localparam int AW  = $clog2(FRAMES);
   localparam int WW  = (LW > PAGE_COUNT_W) ? LW : PAGE_COUNT_W;
   localparam int XW  = (LW > ALLOC_HEAD_W) ? LW : ALLOC_HEAD_W;
   localparam int PBW = $clog2(PAGE_BYTES + 1);
   localparam int MW  = LW + PBW;
   localparam int PW  = (MW > ALLOC_ADDR_W) ? MW : ALLOC_ADDR_W;
   localparam logic [LW-1:0] NIL      = LW'(FRAMES);
   localparam logic [WW-1:0] FRAMES_W = WW'(FRAMES);
   localparam logic [WW-1:0] LAST_W   = WW'(FRAMES - 1);

   logic                    cmd_ff;
   logic [PAGE_COUNT_W-1:0] count_ff;
   logic [CHAIN_HEAD_W-1:0] chead_ff;
   logic                    present_ff;
   logic [LW-1:0]           ptr_ff;
   logic [LW-1:0]           ptr_in;
   logic [LW-1:0]           cur_ff;
   logic [LW-1:0]           head_ff;
   logic [LW-1:0]           free_head_ff;
   logic [LW-1:0]           free_head_in;
   logic [LW-1:0]           free_total_ff;
   logic [LW-1:0]           free_total_in;
   logic [WW-1:0]           cnt_ff;
   logic [WW-1:0]           cnt_in;
   logic [LW-1:0]           chead_lw;
   logic [LW-1:0]           addr_lw;
   logic [LW:0]             total_sum;
   logic [WW-1:0]           total_w;
   logic [XW-1:0]           head_x;
   logic [PW-1:0]           addr_prod;
   logic                    rsp_strobe_ff;
   logic                    rsp_status_ff;
   logic [ALLOC_HEAD_W-1:0] rsp_alloc_head_ff;
   logic [ALLOC_ADDR_W-1:0] rsp_alloc_addr_ff;
   logic [FREE_FRAMES_W-1:0] rsp_free_frames_ff;

   assign chead_lw = LW'(chead_ff);
   assign total_w  = WW'(free_total_ff);
   assign head_x   = XW'(head_ff);
   assign addr_prod = PW'(head_ff) * PW'(PAGE_BYTES);
   assign total_sum = {1'b0, free_total_ff} + {1'b0, cnt_ff[LW-1:0]};

   always_comb begin
      flags              = '0;
      flags.start        = start;
      flags.start_free   = start && (req_cmd == CMD_FREE);
      flags.init_last    = (cnt_ff == LAST_W);
      flags.req_bad      = (count_ff == '0) || (free_head_ff >= NIL);
      flags.cnt_eq_count = (cnt_ff == WW'(count_ff));
      flags.rdata_nil    = (mem_rdata >= NIL);
      flags.free_bad     = !present_ff || (WW'(chead_ff) >= FRAMES_W);
      flags.walk_end     = (cnt_ff == FRAMES_W) || (mem_rdata >= NIL);
   end

   always_comb begin
      case (ctrl.addr_sel)
         ADDR_CNT:       addr_lw = cnt_ff[LW-1:0];
         ADDR_FREE_HEAD: addr_lw = free_head_ff;
         ADDR_CHEAD:     addr_lw = chead_lw;
         ADDR_RDATA:     addr_lw = mem_rdata;
         ADDR_PTR:       addr_lw = ptr_ff;
         default:        addr_lw = ptr_ff;
      endcase
   end

   assign mem_addr = addr_lw[AW-1:0];
   assign mem_we   = ctrl.mem_we;

   always_comb begin
      case (ctrl.wd_sel)
         WD_CNT_NEXT:  mem_wdata = LW'(cnt_ff + WW'(1));
         WD_NIL:       mem_wdata = NIL;
         WD_LINK_HEAD: mem_wdata = (free_head_ff < NIL) ? free_head_ff : NIL;
         default:      mem_wdata = NIL;
      endcase
   end

   always_comb begin
      ptr_in = ptr_ff;
      if (adv) begin
         case (ctrl.ptr_sel)
            PTR_HOLD:      ptr_in = ptr_ff;
            PTR_FREE_HEAD: ptr_in = free_head_ff;
            PTR_CHEAD:     ptr_in = chead_lw;
            PTR_RDATA:     ptr_in = mem_rdata;
            default:       ptr_in = ptr_ff;
         endcase
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (adv) begin
         case (ctrl.cnt_op)
            CNT_HOLD: cnt_in = cnt_ff;
            CNT_ONE:  cnt_in = WW'(1);
            CNT_INC:  cnt_in = cnt_ff + WW'(1);
            default:  cnt_in = cnt_ff;
         endcase
      end
   end

   always_comb begin
      case (ctrl.fh_op)
         FH_HOLD:     free_head_in = free_head_ff;
         FH_FROM_CUR: free_head_in = (cur_ff < NIL) ? cur_ff : NIL;
         FH_CHEAD:    free_head_in = chead_lw;
         default:     free_head_in = free_head_ff;
      endcase
   end

   always_comb begin
      case (ctrl.tot_op)
         TOT_HOLD: free_total_in = free_total_ff;
         TOT_SUB: begin
            if (total_w > WW'(count_ff)) begin
               free_total_in = LW'(total_w - WW'(count_ff));
            end else begin
               free_total_in = '0;
            end
         end
         TOT_ADD: begin
            if (total_sum > (LW + 1)'(FRAMES)) begin
               free_total_in = NIL;
            end else begin
               free_total_in = LW'(total_sum);
            end
         end
         default: free_total_in = free_total_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         free_head_ff  <= '0;
         free_total_ff <= NIL;
         rsp_strobe_ff <= 1'b0;
      end else begin
         cnt_ff        <= cnt_in;
         free_head_ff  <= free_head_in;
         free_total_ff <= free_total_in;
         rsp_strobe_ff <= (ctrl.rsp_op != RSP_NONE);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.idle && start) begin
         cmd_ff     <= req_cmd;
         count_ff   <= req_page_count;
         chead_ff   <= req_chain_head;
         present_ff <= req_chain_present;
      end
      ptr_ff <= ptr_in;
      if (ctrl.cur_ld) begin
         cur_ff <= mem_rdata;
      end
      if (adv && ctrl.head_ld) begin
         head_ff <= free_head_ff;
      end
      case (ctrl.rsp_op)
         RSP_HEAD: begin
            rsp_status_ff      <= STATUS_DONE;
            rsp_alloc_head_ff  <= head_x[ALLOC_HEAD_W-1:0];
            rsp_alloc_addr_ff  <= addr_prod[ALLOC_ADDR_W-1:0];
            rsp_free_frames_ff <= total_w[FREE_FRAMES_W-1:0];
         end
         RSP_PLAIN: begin
            rsp_status_ff      <= STATUS_DONE;
            rsp_alloc_head_ff  <= '0;
            rsp_alloc_addr_ff  <= '0;
            rsp_free_frames_ff <= total_w[FREE_FRAMES_W-1:0];
         end
         RSP_REFUSE: begin
            rsp_status_ff      <= STATUS_REFUSED;
            rsp_alloc_head_ff  <= '0;
            rsp_alloc_addr_ff  <= '0;
            rsp_free_frames_ff <= total_w[FREE_FRAMES_W-1:0];
         end
         default: begin
            rsp_status_ff      <= rsp_status_ff;
         end
      endcase
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_alloc_head  = rsp_alloc_head_ff;
   assign rsp_alloc_addr  = rsp_alloc_addr_ff;
   assign rsp_free_frames = rsp_free_frames_ff;

`ifndef SYNTHESIS
   a_total_bounded: assert property (@(posedge clock) disable iff (reset)
      free_total_ff <= NIL)
      else $error("Free frame count exceeds the pool size.");

   a_alloc_cmd: assert property (@(posedge clock) disable iff (reset)
      (ctrl.rsp_op == RSP_HEAD) |-> (cmd_ff == CMD_ALLOC))
      else $error("Allocation result issued for a free item.");
`endif

endmodule

@@ rtl/page_frame_free_list_allocator_top.sv @@
// ----------------------------------------------------------------------------
// Page frame free-list allocator
// After reset the link table is initialized entry by entry, with busy high
// throughout. An item is taken when start is high and busy is low. An
// allocate of N frames walks N links of the free list and a free of a chain
// of L frames walks its L links; a refused or empty item ends or skips the walk.
// The walk follows one link per cycle through the table's single port. The
// result appears for one cycle with rsp_strobe high, in the cycle busy falls,
// and cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module page_frame_free_list_allocator_top #(
   parameter int FRAMES     = 128,
   parameter int PAGE_BYTES = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_cmd,
   input  logic [pfa_pkg::PAGE_COUNT_W-1:0]  req_page_count,
   input  logic [pfa_pkg::CHAIN_HEAD_W-1:0]  req_chain_head,
   input  logic                              req_chain_present,
   output logic                              rsp_strobe,
   output logic                              rsp_status,
   output logic [pfa_pkg::ALLOC_HEAD_W-1:0]  rsp_alloc_head,
   output logic [pfa_pkg::ALLOC_ADDR_W-1:0]  rsp_alloc_addr,
   output logic [pfa_pkg::FREE_FRAMES_W-1:0] rsp_free_frames
);

   import pfa_pkg::*;

   localparam int LW = $clog2(FRAMES + 1);
   localparam int AW = $clog2(FRAMES);

   ucode_word_type ctrl;
   seq_flags_type  flags;
   logic           adv;
   logic           mem_we;
   logic [AW-1:0]  mem_addr;
   logic [LW-1:0]  mem_wdata;
   logic [LW-1:0]  mem_rdata;

   assign busy = !ctrl.idle;

   pfa_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl),
      .adv   (adv)
   );

   pfa_datapath #(
      .FRAMES     (FRAMES),
      .PAGE_BYTES (PAGE_BYTES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .adv               (adv),
      .start             (start),
      .req_cmd           (req_cmd),
      .req_page_count    (req_page_count),
      .req_chain_head    (req_chain_head),
      .req_chain_present (req_chain_present),
      .flags             (flags),
      .mem_we            (mem_we),
      .mem_addr          (mem_addr),
      .mem_wdata         (mem_wdata),
      .mem_rdata         (mem_rdata),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_alloc_head    (rsp_alloc_head),
      .rsp_alloc_addr    (rsp_alloc_addr),
      .rsp_free_frames   (rsp_free_frames)
   );

   pfa_ram #(
      .WIDTH (LW),
      .DEPTH (FRAMES)
   ) u_next_link (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

`ifndef SYNTHESIS
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("Result shown while the block is still busy.");

   a_accept_to_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_strobe))
      else $error("Accepted item did not start the sequencer.");

   a_refuse_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == STATUS_REFUSED)) |->
      ((rsp_alloc_head == '0) && (rsp_alloc_addr == '0)))
      else $error("Refused item carries a frame index or address.");
`endif

endmodule
